// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Field widths, request codes and payload types shared by the allocator
// and its request/response interfaces.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int ID_W    = 10;  // block_id / alloc_id field width
    localparam int COUNT_W = 11;  // free_count field width
    localparam int WORD_W  = 32;  // bitmap memory word
    localparam int BIT_W   = 5;   // bit index inside one word

    typedef logic [ID_W-1:0]    t_block_id;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [BIT_W-1:0]   t_bit_idx;

    // request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

// ===== rtl/bba_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one allocate or free request.
// ----------------------------------------------------------------------------
interface bba_req_if;
    import bba_pkg::*;

    logic      valid;
    logic      ready;
    logic      op;
    t_block_id block_id;

    modport source (output valid, output op, output block_id, input ready);
    modport sink   (input valid, input op, input block_id, output ready);

endinterface

// ===== rtl/bba_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying the answer to one request.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
    import bba_pkg::*;

    logic      valid;
    logic      ready;
    t_block_id alloc_id;
    logic      granted;
    t_count    free_count;

    modport source (output valid, output alloc_id, output granted, output free_count,
                    input ready);
    modport sink   (input valid, input alloc_id, input granted, input free_count,
                    output ready);

endinterface

// ===== rtl/bba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/block_bitmap_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block bitmap allocator core
// Keeps a used/free bit per block in a word-wide RAM plus a free counter;
// grants the highest-numbered free block and takes blocks back.
// ----------------------------------------------------------------------------
// Usage: after reset the core sweeps the bitmap RAM once, one 32-bit word per
// cycle, to load the reset pattern; requests are held off until then. Each
// request is handled alone. An allocate scans the RAM from the top word
// downward, one word per cycle, reading the next word while checking the
// previous one. An allocate with no free block, and a free of a block number
// at or beyond BLOCK_COUNT, go straight to the response without touching the
// RAM. A free reads the word, clears the bit and writes it back. Freeing a
// block that is already free changes nothing. The response sits in an output
// register, so the next request is taken while the previous response still
// waits for its consumer.
// ----------------------------------------------------------------------------
module block_bitmap_allocator_core #(
    parameter int BLOCK_COUNT     = 1024,
    parameter int RESERVED_BLOCKS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp
);
    import bba_pkg::*;

    localparam int NWORDS  = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
    localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int CW      = $clog2(BLOCK_COUNT + 1);
    localparam int RES_EFF = (RESERVED_BLOCKS > BLOCK_COUNT) ? BLOCK_COUNT
                                                             : RESERVED_BLOCKS;
    localparam int FREE_RST = BLOCK_COUNT - RES_EFF;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_DELIVER
    } t_state;

    // state and registered outputs
    t_state          r_state,      n_state;
    logic [AW-1:0]   r_init_addr,  n_init_addr;
    logic [AW-1:0]   r_addr,       n_addr;       // RAM read address
    logic [AW-1:0]   r_chk_addr,   n_chk_addr;   // word whose data is in rd_data
    logic            r_chk_v,      n_chk_v;
    t_bit_idx        r_bit,        n_bit;        // bit to clear on a free
    logic [CW-1:0]   r_free_cnt,   n_free_cnt;
    t_block_id       r_res_id,     n_res_id;
    logic            r_res_granted, n_res_granted;
    logic            r_out_valid,  n_out_valid;
    t_block_id       r_out_id,     n_out_id;
    logic            r_out_granted, n_out_granted;
    t_count          r_out_cnt,    n_out_cnt;

    // RAM port
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_word           wr_data;
    t_word           rd_data;
    t_word           init_word;

    // decoded request
    logic [31:0]     id_ext;
    logic            id_in_range;
    logic [5:0]      scan_hit;     // {found, bit}
    logic [31:0]     grant_ext;
    logic [31:0]     cnt_ext;

    // Highest clear bit of a bitmap word; MSB of the result flags a hit.
    function automatic logic [5:0] find_free(input t_word w);
        logic [5:0] res;
        res = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (!w[b]) begin
                res = {1'b1, BIT_W'(b)};
            end
        end
        return res;
    endfunction

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS),
        .ADDR_W(AW)
    ) u_map_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(r_addr),
        .o_rd_data(rd_data)
    );

    // Reset pattern of one word: reserved blocks used, blocks past the end of
    // the store marked used so the scan never hands them out.
    always_comb begin
        int idx;
        idx = 0;
        for (int b = 0; b < WORD_W; b++) begin
            idx = int'(r_init_addr) * WORD_W + b;
            init_word[b] = (idx < RES_EFF) || (idx >= BLOCK_COUNT);
        end
    end

    assign id_ext      = 32'(i_req.block_id);
    assign id_in_range = (id_ext < 32'(BLOCK_COUNT));
    assign scan_hit    = find_free(rd_data);
    assign grant_ext   = 32'({r_chk_addr, scan_hit[BIT_W-1:0]});
    assign cnt_ext     = 32'(r_free_cnt);

    // Next-state and RAM write control
    always_comb begin
        n_state       = r_state;
        n_init_addr   = r_init_addr;
        n_addr        = r_addr;
        n_chk_addr    = r_chk_addr;
        n_chk_v       = 1'b0;
        n_bit         = r_bit;
        n_free_cnt    = r_free_cnt;
        n_res_id      = r_res_id;
        n_res_granted = r_res_granted;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_id      = r_out_id;
        n_out_granted = r_out_granted;
        n_out_cnt     = r_out_cnt;
        wr_en         = 1'b0;
        wr_addr       = r_chk_addr;
        wr_data       = rd_data;

        unique case (r_state)
            ST_INIT: begin
                // sweep the reset pattern into the RAM
                wr_en       = 1'b1;
                wr_addr     = r_init_addr;
                wr_data     = init_word;
                n_init_addr = r_init_addr + 1'b1;
                if (r_init_addr == AW'(NWORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_res_id      = '0;
                    n_res_granted = 1'b0;
                    if (i_req.op == OP_ALLOC) begin
                        if (r_free_cnt == '0) begin
                            n_state = ST_DELIVER;
                        end else begin
                            n_addr  = AW'(NWORDS - 1);
                            n_state = ST_SCAN;
                        end
                    end else if (id_in_range) begin
                        n_addr  = id_ext[AW+BIT_W-1:BIT_W];
                        n_bit   = id_ext[BIT_W-1:0];
                        n_state = ST_FREE_RD;
                    end else begin
                        n_state = ST_DELIVER;
                    end
                end
            end
            ST_SCAN: begin
                // issue the next word while checking the previous one
                n_addr     = r_addr - 1'b1;
                n_chk_addr = r_addr;
                n_chk_v    = 1'b1;
                if (r_chk_v && scan_hit[BIT_W]) begin
                    wr_en         = 1'b1;
                    wr_data       = rd_data | (t_word'(1) << scan_hit[BIT_W-1:0]);
                    n_free_cnt    = r_free_cnt - 1'b1;
                    n_res_id      = grant_ext[ID_W-1:0];
                    n_res_granted = 1'b1;
                    n_chk_v       = 1'b0;
                    n_state       = ST_DELIVER;
                end
            end
            ST_FREE_RD: begin
                n_chk_addr = r_addr;
                n_state    = ST_FREE_CHK;
            end
            ST_FREE_CHK: begin
                if (rd_data[r_bit]) begin
                    wr_en      = 1'b1;
                    wr_data    = rd_data & ~(t_word'(1) << r_bit);
                    n_free_cnt = r_free_cnt + 1'b1;
                end
                n_state = ST_DELIVER;
            end
            ST_DELIVER: begin
                // load the output register once it is empty or draining
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_id      = r_res_id;
                    n_out_granted = r_res_granted;
                    n_out_cnt     = cnt_ext[COUNT_W-1:0];
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init_addr <= '0;
            r_chk_v     <= 1'b0;
            r_free_cnt  <= CW'(FREE_RST);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_chk_v     <= n_chk_v;
            r_free_cnt  <= n_free_cnt;
            r_out_valid <= n_out_valid;
        end
        r_addr        <= n_addr;
        r_chk_addr    <= n_chk_addr;
        r_bit         <= n_bit;
        r_res_id      <= n_res_id;
        r_res_granted <= n_res_granted;
        r_out_id      <= n_out_id;
        r_out_granted <= n_out_granted;
        r_out_cnt     <= n_out_cnt;
    end

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.alloc_id   = r_out_id;
    assign o_rsp.granted    = r_out_granted;
    assign o_rsp.free_count = r_out_cnt;

    // The free counter never exceeds the store size.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CW'(BLOCK_COUNT))
        else $error("free count above block count");

    // A scan only runs while at least one block is free.
    a_scan_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_free_cnt != '0)
        else $error("scan started with no free block");

    // A grant lowers the count by one on the next cycle.
    a_grant_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && wr_en) |=> r_free_cnt == $past(r_free_cnt) - 1'b1)
        else $error("grant did not lower the free count");

    // A cleared bit raises the count by one on the next cycle.
    a_free_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FREE_CHK && wr_en) |=> r_free_cnt == $past(r_free_cnt) + 1'b1)
        else $error("free did not raise the free count");

    // The RAM is written only by the init sweep, a grant or a free.
    a_wr_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == ST_INIT || r_state == ST_SCAN || r_state == ST_FREE_CHK))
        else $error("unexpected bitmap write");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block bitmap allocator testbench
// Drives allocate and free requests into the allocator core under random
// idling on both channels, predicts every response from a private copy of
// the used map and the free count, and checks each response field by field.
// ----------------------------------------------------------------------------
module testbench;
    import bba_pkg::*;

    localparam int BLOCK_COUNT     = 1024;
    localparam int RESERVED_BLOCKS = 32;
    localparam int CLK_HALF        = 2;     // 4 ns period
    localparam int RESET_CYCLES    = 6;
    localparam int IDLE_MAX        = 19;    // longest gap or stall per request
    // Longest legal quiet stretch: reset sweep, then a full-depth scan while
    // both sides idle; the limit takes that several times over.
    localparam int QUIET_LIMIT     = 1000;
    localparam int SETTLE_CYCLES   = 40;    // longest scan plus margin
    localparam int REPORT_MAX      = 40;

    typedef struct packed {
        t_block_id alloc_id;
        logic      granted;
        t_count    free_count;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    block_bitmap_allocator_core #(
        .BLOCK_COUNT     (BLOCK_COUNT),
        .RESERVED_BLOCKS (RESERVED_BLOCKS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Private copy of the allocator state.
    bit      block_used [BLOCK_COUNT];
    int      free_left;
    t_answer answers_due [$];

    int fail_count   = 0;
    int sent_count   = 0;
    int quiet_cycles = 0;
    int src_idle_max = IDLE_MAX;
    int rsp_idle_max = IDLE_MAX;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Allocator state prediction
    // ------------------------------------------------------------------------
    function automatic void clear_block_map();
        int reserved;
        reserved = (RESERVED_BLOCKS > BLOCK_COUNT) ? BLOCK_COUNT : RESERVED_BLOCKS;
        for (int k = 0; k < BLOCK_COUNT; k++) block_used[k] = (k < reserved);
        free_left = BLOCK_COUNT - reserved;
    endfunction

    // Apply one request to the private state; return the response it causes.
    function automatic t_answer allocate_or_release(input logic op, input t_block_id id);
        t_answer ans;
        ans.alloc_id = '0;
        ans.granted  = 1'b0;
        if (op == OP_ALLOC) begin
            // Take the highest-numbered free block; a full store changes nothing.
            for (int k = BLOCK_COUNT - 1; k >= 0; k--) begin
                if (!block_used[k]) begin
                    block_used[k] = 1'b1;
                    free_left--;
                    ans.alloc_id = t_block_id'(k);
                    ans.granted  = 1'b1;
                    break;
                end
            end
        end else if (int'(id) < BLOCK_COUNT && block_used[id]) begin
            // Release only a block that is marked used, reserved ones included.
            block_used[id] = 1'b0;
            free_left++;
        end
        ans.free_count = t_count'(free_left);
        return ans;
    endfunction

    // Pick a used block starting from a random point, so that most frees hit.
    function automatic t_block_id pick_used_block();
        int start;
        int k;
        start = $urandom_range(0, BLOCK_COUNT - 1);
        for (int i = 0; i < BLOCK_COUNT; i++) begin
            k = (start + i) % BLOCK_COUNT;
            if (block_used[k]) return t_block_id'(k);
        end
        return t_block_id'(start);
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_count < REPORT_MAX)
            $display("[%0t] mismatch: %s got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Hold off a random number of cycles, then present one request and wait
    // for it to be taken. Valid stays high when the next request follows at
    // once, so it is never lowered and raised in the same step.
    task automatic send_request(input logic op, input t_block_id id);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.block_id <= id;
        do @(posedge i_clk); while (!req_ch.ready);
        answers_due.push_back(allocate_or_release(op, id));
        sent_count++;
    endtask

    // Drop valid and wait until every outstanding response has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (answers_due.size() > 0) @(posedge i_clk);
    endtask

    // One random request; alloc_pct sets the drift toward a full or empty store.
    task automatic random_request(input int alloc_pct);
        t_block_id id;
        // Reshuffle idling on both sides now and then, leaving some stretches
        // with none at all.
        if (sent_count % 64 == 0) begin
            src_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
            rsp_idle_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
        end
        if ($urandom_range(0, 99) < alloc_pct) begin
            // block_id is ignored on allocate; drive noise on it anyway
            send_request(OP_ALLOC, t_block_id'($urandom));
        end else begin
            id = ($urandom_range(0, 3) != 0) ? pick_used_block()
                                             : t_block_id'($urandom_range(0, BLOCK_COUNT - 1));
            send_request(OP_FREE, id);
        end
    endtask

    // ------------------------------------------------------------------------
    // Response side: stall at random, then check each response against the
    // oldest expected answer.
    // ------------------------------------------------------------------------
    initial begin
        int      stall;
        t_answer want;
        rsp_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = $urandom_range(0, rsp_idle_max);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready));
            if (answers_due.size() == 0) begin
                report_mismatch("unexpected response, alloc_id", int'(rsp_ch.alloc_id), -1);
            end else begin
                want = answers_due.pop_front();
                if (rsp_ch.alloc_id !== want.alloc_id)
                    report_mismatch("alloc_id", int'(rsp_ch.alloc_id), int'(want.alloc_id));
                if (rsp_ch.granted !== want.granted)
                    report_mismatch("granted", int'(rsp_ch.granted), int'(want.granted));
                if (rsp_ch.free_count !== want.free_count)
                    report_mismatch("free_count", int'(rsp_ch.free_count),
                                    int'(want.free_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles in which neither channel moves a request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Grants come from the top of the store; a freed block is granted again,
    // and a second free of the same block is ignored.
    task automatic test_top_grants();
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '1);
        send_request(OP_ALLOC, t_block_id'(10'h155));
        send_request(OP_FREE, t_block_id'(BLOCK_COUNT - 2));
        send_request(OP_ALLOC, t_block_id'(10'h2AA));
        send_request(OP_FREE, t_block_id'(BLOCK_COUNT - 2));
        send_request(OP_FREE, t_block_id'(BLOCK_COUNT - 2));
    endtask

    // Reserved blocks may be freed like any used block; frees of blocks that
    // are already free leave the count alone.
    task automatic test_free_cases();
        send_request(OP_FREE, t_block_id'(0));
        send_request(OP_FREE, t_block_id'(RESERVED_BLOCKS - 1));
        send_request(OP_FREE, t_block_id'(0));
        send_request(OP_FREE, t_block_id'(RESERVED_BLOCKS));
        send_request(OP_FREE, t_block_id'(10'h2AA));
        send_request(OP_FREE, t_block_id'(10'h155));
        send_request(OP_FREE, t_block_id'(BLOCK_COUNT - 1));
        send_request(OP_FREE, t_block_id'(BLOCK_COUNT - 1));
        // hold off until the core has answered everything
        wait_drained();
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
    endtask

    // Drift toward a full store, which also grants the freed reserved blocks
    // (block 0 last), keep allocating on a full store, then free the top block and take it back.
    task automatic test_fill_to_full();
        while (free_left > 0) random_request(98);
        repeat (8) send_request(OP_ALLOC, t_block_id'($urandom));
        send_request(OP_FREE, t_block_id'(BLOCK_COUNT - 1));
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        wait_drained();
    endtask

    // Random churn that drifts back toward an empty store.
    task automatic test_churn();
        repeat (50) random_request(30);
        wait_drained();
        repeat (40) random_request(55);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_ALLOC;
        req_ch.block_id <= '0;
        clear_block_map();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_top_grants();
        test_free_cases();
        test_fill_to_full();
        test_churn();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
